[rtl/hsv_pkg.sv]
// ----------------------------------------------------------------------------
// hsv_pkg
// shared widths, constants and the sector type for the hsv to rgb block
// ----------------------------------------------------------------------------
package hsv_pkg;

   localparam int HUE_W  = 13;
   localparam int FRAC_W = 12;
   localparam int CH_W   = 8;
   localparam int FACT_W = 20;

   // 1.0 in channel units, 1.0 in hue units, and their product
   localparam logic [CH_W-1:0]   FULL     = 8'd255;
   localparam logic [FRAC_W:0]   ONE_FRAC = 13'd4096;
   localparam logic [FACT_W-1:0] SCALE    = 20'd1044480;

   // hue sector, one sixth of a turn each
   typedef enum logic [2:0] {
      SEC_RED_YEL = 3'd0,
      SEC_YEL_GRN = 3'd1,
      SEC_GRN_CYN = 3'd2,
      SEC_CYN_BLU = 3'd3,
      SEC_BLU_MAG = 3'd4,
      SEC_MAG_RED = 3'd5
   } sector_type;

endpackage

[rtl/hsv_req_if.sv]
// ----------------------------------------------------------------------------
// hsv_req_if
// input word channel: one hsv color plus alpha
// ----------------------------------------------------------------------------
interface hsv_req_if;
   import hsv_pkg::*;

   logic              valid;
   logic              ready;
   logic [HUE_W-1:0]  hue;
   logic [CH_W-1:0]   saturation;
   logic [CH_W-1:0]   brightness;
   logic [CH_W-1:0]   alpha;

   modport source (output valid, hue, saturation, brightness, alpha, input ready);
   modport sink   (input valid, hue, saturation, brightness, alpha, output ready);
endinterface

[rtl/hsv_rsp_if.sv]
// ----------------------------------------------------------------------------
// hsv_rsp_if
// result word channel: one rgb color plus alpha
// ----------------------------------------------------------------------------
interface hsv_rsp_if;
   import hsv_pkg::*;

   logic             valid;
   logic             ready;
   logic [CH_W-1:0]  red;
   logic [CH_W-1:0]  green;
   logic [CH_W-1:0]  blue;
   logic [CH_W-1:0]  alpha_out;

   modport source (output valid, red, green, blue, alpha_out, input ready);
   modport sink   (input valid, red, green, blue, alpha_out, output ready);
endinterface

[rtl/hsv_to_rgb_converter_core.sv]
// an accepted input word passes four register stages (sector and fraction,
//   factors, brightness products, divide by 255 and channel select) before
//   its result word shows on rsp; one word per cycle while rsp does not stall
// a stall on rsp holds the full stages after the last empty one; empty stages still fill
// reset (synchronous) clears the stage valid bits only, data is not reset
// ----------------------------------------------------------------------------
// hsv_to_rgb_converter_core
// pipelined hsv to rgb conversion in fixed point, alpha passes through
// ----------------------------------------------------------------------------
module hsv_to_rgb_converter_core (
   input  logic      clock,
   input  logic      reset,
   hsv_req_if.sink   req_chan,
   hsv_rsp_if.source rsp_chan
);
   import hsv_pkg::*;

   // floor(n / 255) for n up to 65025, the largest numerator that reaches it
   function automatic logic [CH_W-1:0] div255(input logic [15:0] n);
      logic [16:0] sum;
      sum = {1'b0, n} + 17'(n[15:8]) + 17'd1;
      return sum[15:8];
   endfunction

   // stage enables: a stage loads when it is empty or its contents move on
   logic out_en, s3_en, s2_en, s1_en;

   // stage 1: sector and fraction of hue * 6
   logic              s1_vld_ff;
   sector_type        s1_sector_ff, s1_sector_in;
   logic [FRAC_W-1:0] s1_frac_ff, s1_frac_in;
   logic [CH_W-1:0]   s1_sat_ff, s1_val_ff, s1_alpha_ff;
   logic [FRAC_W+2:0] hue6;

   // stage 2: q and t factors, numerator of p
   logic              s2_vld_ff;
   sector_type        s2_sector_ff;
   logic [CH_W-1:0]   s2_val_ff, s2_alpha_ff;
   logic [FACT_W-1:0] s2_fq_ff, s2_fq_in, s2_ft_ff, s2_ft_in;
   logic [15:0]       s2_pn_ff, s2_pn_in;
   logic [FACT_W-1:0] sat_frac;
   logic [FACT_W-1:0] sat_cofrac;

   // stage 3: brightness times factor, already divided by 4096
   logic                     s3_vld_ff;
   sector_type               s3_sector_ff;
   logic [CH_W-1:0]          s3_val_ff, s3_alpha_ff;
   logic [15:0]              s3_qn_ff, s3_tn_ff, s3_pn_ff;
   logic [FACT_W+CH_W-1:0]   prod_q, prod_t;

   // output register
   logic            rsp_vld_ff;
   logic [CH_W-1:0] red_ff, green_ff, blue_ff, alpha_ff;
   logic [CH_W-1:0] red_in, green_in, blue_in;
   logic [CH_W-1:0] p_val, q_val, t_val;

   assign out_en = !rsp_vld_ff || rsp_chan.ready;
   assign s3_en  = !s3_vld_ff || out_en;
   assign s2_en  = !s2_vld_ff || s3_en;
   assign s1_en  = !s1_vld_ff || s2_en;

   assign req_chan.ready = s1_en;

   // ---- stage 1 ----
   // bit 12 of hue is dropped, so a full turn wraps to zero
   always_comb begin
      hue6         = 15'(req_chan.hue[FRAC_W-1:0]) * 15'd6;
      s1_sector_in = sector_type'(hue6[FRAC_W+2:FRAC_W]);
      s1_frac_in   = hue6[FRAC_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff <= 1'b0;
      end else if (s1_en) begin
         s1_vld_ff <= req_chan.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_en) begin
         s1_sector_ff <= s1_sector_in;
         s1_frac_ff   <= s1_frac_in;
         s1_sat_ff    <= req_chan.saturation;
         s1_val_ff    <= req_chan.brightness;
         s1_alpha_ff  <= req_chan.alpha;
      end
   end

   // ---- stage 2 ----
   // fq = 255*4096 - s*f, ft = 255*4096 - s*(4096-f), pn = v*(255-s)
   always_comb begin
      sat_frac   = FACT_W'(s1_sat_ff) * FACT_W'(s1_frac_ff);
      sat_cofrac = FACT_W'(s1_sat_ff) * FACT_W'(ONE_FRAC - {1'b0, s1_frac_ff});
      s2_fq_in   = SCALE - sat_frac;
      s2_ft_in   = SCALE - sat_cofrac;
      s2_pn_in   = 16'(s1_val_ff) * 16'(FULL - s1_sat_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_vld_ff <= 1'b0;
      end else if (s2_en) begin
         s2_vld_ff <= s1_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (s2_en) begin
         s2_sector_ff <= s1_sector_ff;
         s2_val_ff    <= s1_val_ff;
         s2_alpha_ff  <= s1_alpha_ff;
         s2_fq_ff     <= s2_fq_in;
         s2_ft_ff     <= s2_ft_in;
         s2_pn_ff     <= s2_pn_in;
      end
   end

   // ---- stage 3 ----
   // dividing by 255*4096 is a drop of 12 bits then a divide by 255
   always_comb begin
      prod_q = (FACT_W+CH_W)'(s2_val_ff) * (FACT_W+CH_W)'(s2_fq_ff);
      prod_t = (FACT_W+CH_W)'(s2_val_ff) * (FACT_W+CH_W)'(s2_ft_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_vld_ff <= 1'b0;
      end else if (s3_en) begin
         s3_vld_ff <= s2_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (s3_en) begin
         s3_sector_ff <= s2_sector_ff;
         s3_val_ff    <= s2_val_ff;
         s3_alpha_ff  <= s2_alpha_ff;
         s3_qn_ff     <= prod_q[FACT_W+CH_W-1:FRAC_W];
         s3_tn_ff     <= prod_t[FACT_W+CH_W-1:FRAC_W];
         s3_pn_ff     <= s2_pn_ff;
      end
   end

   // ---- stage 4: divide by 255 and pick channels by sector ----
   always_comb begin
      p_val = div255(s3_pn_ff);
      q_val = div255(s3_qn_ff);
      t_val = div255(s3_tn_ff);
      case (s3_sector_ff)
         SEC_RED_YEL: begin
            red_in = s3_val_ff; green_in = t_val;     blue_in = p_val;
         end
         SEC_YEL_GRN: begin
            red_in = q_val;     green_in = s3_val_ff; blue_in = p_val;
         end
         SEC_GRN_CYN: begin
            red_in = p_val;     green_in = s3_val_ff; blue_in = t_val;
         end
         SEC_CYN_BLU: begin
            red_in = p_val;     green_in = q_val;     blue_in = s3_val_ff;
         end
         SEC_BLU_MAG: begin
            red_in = t_val;     green_in = p_val;     blue_in = s3_val_ff;
         end
         default: begin
            red_in = s3_val_ff; green_in = p_val;     blue_in = q_val;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_vld_ff <= 1'b0;
      end else if (out_en) begin
         rsp_vld_ff <= s3_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (out_en) begin
         red_ff   <= red_in;
         green_ff <= green_in;
         blue_ff  <= blue_in;
         alpha_ff <= s3_alpha_ff;
      end
   end

   assign rsp_chan.valid     = rsp_vld_ff;
   assign rsp_chan.red       = red_ff;
   assign rsp_chan.green     = green_ff;
   assign rsp_chan.blue      = blue_ff;
   assign rsp_chan.alpha_out = alpha_ff;

endmodule

[tb/hsv_to_rgb_converter_core_tb.sv]
// ----------------------------------------------------------------------------
// hsv_to_rgb_converter_core_tb
// drives hsv colors into the converter and checks every rgb word it returns
// against the table's answer or an in-bench fixed-point predictor: a directed
// table of extremes, sector edges and wrapped hues first, then random colors with
// random handshake gaps, a long receiver hold-off and a full drain in the middle
// ----------------------------------------------------------------------------
module hsv_to_rgb_converter_core_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import hsv_pkg::*;

   localparam int HALF_PERIOD   = 5;
   localparam int RESET_CYCLES  = 7;
   localparam int RANDOM_COLORS = 700;
   localparam int IDLE_PCT      = 34;
   localparam int STALL_LIMIT   = 2000;
   localparam int DRAIN_CYCLES  = 8;    // pipeline is four stages deep
   localparam int HOLD_CYCLES   = 60;
   localparam int HOLD_AT       = 200;  // results seen when the long hold-off starts
   localparam int SEND_EAGER_LO = 150;  // random colors sent back to back
   localparam int SEND_EAGER_HI = 330;
   localparam int SEND_PAUSE_AT = 400;  // random color before which the sender drains
   localparam int RECV_EAGER_LO = 450;  // results taken back to back
   localparam int RECV_EAGER_HI = 580;
   localparam int DIRECTED_ROWS = 25;

   typedef struct packed {
      logic [HUE_W-1:0] hue;
      logic [CH_W-1:0]  saturation;
      logic [CH_W-1:0]  brightness;
      logic [CH_W-1:0]  alpha;
   } hsva_type;

   typedef struct packed {
      logic [CH_W-1:0] red;
      logic [CH_W-1:0] green;
      logic [CH_W-1:0] blue;
      logic [CH_W-1:0] alpha_out;
   } rgba_type;

   // typed = 1 means the rgba column is the answer, otherwise the predictor decides
   typedef struct packed {
      hsva_type color;
      logic     typed;
      rgba_type rgba;
   } stim_row_type;

   localparam stim_row_type DIRECTED [DIRECTED_ROWS] = '{
      // pure red at full scale, first word after reset
      '{'{13'd0,    8'd255, 8'd255, 8'hff}, 1'b1, '{8'd255, 8'd0,   8'd0,   8'hff}},
      // one full turn acts as hue zero
      '{'{13'd4096, 8'd255, 8'd255, 8'h00}, 1'b1, '{8'd255, 8'd0,   8'd0,   8'h00}},
      // half a turn is cyan
      '{'{13'd2048, 8'd255, 8'd255, 8'h5a}, 1'b1, '{8'd0,   8'd255, 8'd255, 8'h5a}},
      // no saturation, every channel equals brightness
      '{'{13'd1000, 8'd0,   8'd200, 8'h01}, 1'b1, '{8'd200, 8'd200, 8'd200, 8'h01}},
      '{'{13'd8191, 8'd0,   8'd255, 8'hfe}, 1'b1, '{8'd255, 8'd255, 8'd255, 8'hfe}},
      // zero brightness is black whatever the hue
      '{'{13'd3000, 8'd255, 8'd0,   8'h80}, 1'b1, '{8'd0,   8'd0,   8'd0,   8'h80}},
      // hue above one turn wraps, bit 12 is dropped
      '{'{13'd6144, 8'd255, 8'd255, 8'ha5}, 1'b1, '{8'd0,   8'd255, 8'd255, 8'ha5}},
      // middle of each sector
      '{'{13'd341,  8'd200, 8'd180, 8'h55}, 1'b0, '0},
      '{'{13'd1024, 8'd200, 8'd180, 8'haa}, 1'b0, '0},
      '{'{13'd1707, 8'd128, 8'd255, 8'h0f}, 1'b0, '0},
      '{'{13'd2389, 8'd254, 8'd1,   8'hf0}, 1'b0, '0},
      '{'{13'd3072, 8'd1,   8'd254, 8'h33}, 1'b0, '0},
      '{'{13'd3755, 8'd77,  8'd99,  8'hcc}, 1'b0, '0},
      // both sides of each sector edge except the one at half a turn
      '{'{13'd682,  8'd255, 8'd255, 8'h00}, 1'b0, '0},
      '{'{13'd683,  8'd255, 8'd255, 8'hff}, 1'b0, '0},
      '{'{13'd1365, 8'd255, 8'd255, 8'h00}, 1'b0, '0},
      '{'{13'd1366, 8'd255, 8'd255, 8'hff}, 1'b0, '0},
      '{'{13'd2730, 8'd255, 8'd255, 8'h00}, 1'b0, '0},
      '{'{13'd2731, 8'd255, 8'd255, 8'hff}, 1'b0, '0},
      '{'{13'd3413, 8'd255, 8'd255, 8'h00}, 1'b0, '0},
      '{'{13'd3414, 8'd255, 8'd255, 8'hff}, 1'b0, '0},
      '{'{13'd4095, 8'd255, 8'd255, 8'h55}, 1'b0, '0},
      // wrapped hues
      '{'{13'd4097, 8'd255, 8'd255, 8'haa}, 1'b0, '0},
      '{'{13'd5461, 8'd170, 8'd240, 8'h3c}, 1'b0, '0},
      '{'{13'd8190, 8'd255, 8'd128, 8'hc3}, 1'b0, '0}
   };

   logic clock;
   logic reset;

   hsv_req_if req_if ();
   hsv_rsp_if rsp_if ();

   hsv_to_rgb_converter_core DUT (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_if),
      .rsp_chan (rsp_if)
   );

   rgba_type expected_rgba [$];   // one entry per accepted color, oldest first
   int       errors;
   int       colors_seen;
   int       idle_cycles;
   bit       sender_eager;        // no gaps on the input side while set

   // ------------------------------------------------------------------------
   // clock and reset
   // ------------------------------------------------------------------------
   initial clock = 1'b0;
   always #(HALF_PERIOD) clock = ~clock;

   initial begin
      reset = 1'b1;
      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
   end

   // ------------------------------------------------------------------------
   // predictor: hsv to rgb in exact integer arithmetic
   // ------------------------------------------------------------------------
   function automatic rgba_type predict_rgba(input hsva_type color);
      logic [14:0] h6;        // low 12 hue bits times six, at most 24570
      sector_type  sector;
      logic [63:0] s, v, f;
      logic [63:0] p, q, t;
      rgba_type    o;

      h6     = 15'(color.hue[FRAC_W-1:0]) * 15'd6;
      sector = sector_type'(h6[14:FRAC_W]);
      f      = 64'(h6[FRAC_W-1:0]);
      s      = 64'(color.saturation);
      v      = 64'(color.brightness);

      // q and t are scaled to 255 * 4096, p to 255, and each is truncated
      p = (v * (64'(FULL) - s)) / 64'(FULL);
      q = (v * (64'(SCALE) - s * f)) / 64'(SCALE);
      t = (v * (64'(SCALE) - s * (64'(ONE_FRAC) - f))) / 64'(SCALE);

      case (sector)
         SEC_RED_YEL: begin o.red = v[7:0]; o.green = t[7:0]; o.blue = p[7:0]; end
         SEC_YEL_GRN: begin o.red = q[7:0]; o.green = v[7:0]; o.blue = p[7:0]; end
         SEC_GRN_CYN: begin o.red = p[7:0]; o.green = v[7:0]; o.blue = t[7:0]; end
         SEC_CYN_BLU: begin o.red = p[7:0]; o.green = q[7:0]; o.blue = v[7:0]; end
         SEC_BLU_MAG: begin o.red = t[7:0]; o.green = p[7:0]; o.blue = v[7:0]; end
         default:     begin o.red = v[7:0]; o.green = p[7:0]; o.blue = q[7:0]; end
      endcase
      o.alpha_out = color.alpha;
      return o;
   endfunction

   // ------------------------------------------------------------------------
   // random colors, weighted toward hue circle corners, wrapped hues and extreme s, v
   // ------------------------------------------------------------------------
   function automatic hsva_type random_color();
      hsva_type    c;
      int unsigned k;

      c.saturation = CH_W'($urandom_range(0, 255));
      c.brightness = CH_W'($urandom_range(0, 255));
      c.alpha      = CH_W'($urandom_range(0, 255));
      c.hue        = HUE_W'($urandom_range(0, ONE_FRAC));

      case ($urandom_range(0, 9))
         0: c.hue = $urandom_range(0, 1) ? ONE_FRAC : '0;
         1: begin
            // just below, on or just above a sector edge
            k     = $urandom_range(0, 6);
            c.hue = HUE_W'((k * ONE_FRAC) / 6 + $urandom_range(0, 2) - (k > 0 ? 1 : 0));
         end
         2: begin
            c.saturation = $urandom_range(0, 1) ? FULL : '0;
            c.brightness = $urandom_range(0, 1) ? FULL : '0;
         end
         3: c.hue = HUE_W'($urandom_range(ONE_FRAC + 1, 8191));
         default: ;
      endcase
      return c;
   endfunction

   // ------------------------------------------------------------------------
   // input side: drive at the falling edge, accept at the rising edge
   // ------------------------------------------------------------------------
   task automatic send_color(input hsva_type color, input rgba_type rgba);
      @(negedge clock);
      while (!sender_eager && $urandom_range(0, 99) < IDLE_PCT) begin
         req_if.valid <= 1'b0;
         @(negedge clock);
      end
      req_if.valid      <= 1'b1;
      req_if.hue        <= color.hue;
      req_if.saturation <= color.saturation;
      req_if.brightness <= color.brightness;
      req_if.alpha      <= color.alpha;
      do @(posedge clock); while (!(req_if.valid && req_if.ready));
      expected_rgba.push_back(rgba);
   endtask

   // drop valid and hold off until every expected word has come back
   task automatic drain_pipeline();
      @(negedge clock);
      req_if.valid <= 1'b0;
      while (expected_rgba.size() != 0) @(posedge clock);
   endtask

   task automatic check_channel(input string name, input logic [CH_W-1:0] want,
                                input logic [CH_W-1:0] got);
      if (got !== want) begin
         errors++;
         $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
      end
   endtask

   // ------------------------------------------------------------------------
   // stimulus
   // ------------------------------------------------------------------------
   initial begin
      hsva_type color;

      errors            = 0;
      sender_eager      = 1'b0;
      req_if.valid      = 1'b0;
      req_if.hue        = '0;
      req_if.saturation = '0;
      req_if.brightness = '0;
      req_if.alpha      = '0;

      @(negedge clock);
      while (reset) @(negedge clock);

      // directed table
      for (int i = 0; i < DIRECTED_ROWS; i++) begin
         send_color(DIRECTED[i].color,
                    DIRECTED[i].typed ? DIRECTED[i].rgba : predict_rgba(DIRECTED[i].color));
      end
      drain_pipeline();

      // random colors; a back-to-back window lines up with the receiver hold-off
      // so the pipeline fills and pushes back on the input
      for (int i = 0; i < RANDOM_COLORS; i++) begin
         if (i == SEND_PAUSE_AT)
            drain_pipeline();
         sender_eager = (i >= SEND_EAGER_LO && i < SEND_EAGER_HI);
         color        = random_color();
         send_color(color, predict_rgba(color));
      end
      sender_eager = 1'b0;
      drain_pipeline();

      // wait out DRAIN_CYCLES so a stray extra word still gets caught
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (errors == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

   // ------------------------------------------------------------------------
   // result side: random ready, one long hold-off, one gap-free stretch
   // ------------------------------------------------------------------------
   initial begin
      int hold_left;
      bit hold_done;

      hold_left    = 0;
      hold_done    = 1'b0;
      rsp_if.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_left != 0) begin
            rsp_if.ready <= 1'b0;
            hold_left--;
         end else if (!hold_done && colors_seen >= HOLD_AT) begin
            hold_done    = 1'b1;
            hold_left    = HOLD_CYCLES - 1;
            rsp_if.ready <= 1'b0;
         end else if (colors_seen >= RECV_EAGER_LO && colors_seen < RECV_EAGER_HI) begin
            rsp_if.ready <= 1'b1;
         end else begin
            rsp_if.ready <= ($urandom_range(0, 99) >= IDLE_PCT);
         end
      end
   end

   // ------------------------------------------------------------------------
   // result checker: each accepted word against the oldest expectation
   // ------------------------------------------------------------------------
   initial colors_seen = 0;

   always @(posedge clock) begin
      rgba_type want;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         colors_seen++;
         if (expected_rgba.size() == 0) begin
            errors++;
            $display("%0t: unexpected word, expected none, got r=%0d g=%0d b=%0d a=%0d",
                     $time, rsp_if.red, rsp_if.green, rsp_if.blue, rsp_if.alpha_out);
         end else begin
            want = expected_rgba.pop_front();
            check_channel("red",       want.red,       rsp_if.red);
            check_channel("green",     want.green,     rsp_if.green);
            check_channel("blue",      want.blue,      rsp_if.blue);
            check_channel("alpha_out", want.alpha_out, rsp_if.alpha_out);
         end
      end
   end

   // ------------------------------------------------------------------------
   // watchdog: too long without any word moving on either side
   // ------------------------------------------------------------------------
   initial idle_cycles = 0;

   always @(posedge clock) begin
      if (reset || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= STALL_LIMIT) begin
         $display("%0t: timeout, no word moved in %0d cycles", $time, idle_cycles);
         $display("DONE: errors detected");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

endmodule

[files.f]
rtl/hsv_pkg.sv
rtl/hsv_req_if.sv
rtl/hsv_rsp_if.sv
rtl/hsv_to_rgb_converter_core.sv
tb/hsv_to_rgb_converter_core_tb.sv
